// ===== hdl/see_pkg.sv =====
// Package for the stack expression evaluator.
// Holds sizes, operator and status codes and the arithmetic unit's request and response types.
// No dependencies; every other file in hdl imports it.
`default_nettype none

package see_pkg;

  // Default number of operand stack entries.
  localparam int unsigned SEE_STACK_DEPTH = 16;

  // Width of an operand value.
  localparam int unsigned SEE_DATA_W = 32;

  // Operator codes carried by an operator token.
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_REM = 3'd5
  } see_op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_LEFTOVER  = 3'd4
  } see_status_t;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    see_op_t op;
  } see_alu_req_t;

  // Completion report from the arithmetic unit.
  typedef struct packed {
    logic done;
    logic div0;
  } see_alu_rsp_t;

  // The first error of an expression is kept; later ones are dropped.
  function automatic see_status_t see_note_err(see_status_t cur, see_status_t code);
    see_status_t res;
    res = (cur == ST_OK) ? code : cur;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/see_if.sv =====
// Channel interfaces of the stack expression evaluator: token input and result output.
// Depends on see_pkg for the data width.
`default_nettype none

// One token: an operand push or an operator.
interface see_tok_if;
  import see_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [SEE_DATA_W-1:0] operand_value;
  logic [2:0]                   operator_code;
  logic                         last_token;

  modport source (output valid, output mode, output operand_value, output operator_code,
                  output last_token, input ready);
  modport sink (input valid, input mode, input operand_value, input operator_code,
                input last_token, output ready);
endinterface

// One expression result.
interface see_res_if;
  import see_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SEE_DATA_W-1:0] result_value;
  logic [2:0]                   status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/stack_expression_evaluator.sv =====
// Top level of the stack expression evaluator: token sequencer, operand stack memory
// and result register. Depends on see_pkg, see_if (see_tok_if, see_res_if) and see_alu.
`default_nettype none

// Channel    Dir  Handshake      Payload
// in_tok     in   valid/ready    mode, operand_value, operator_code, last_token
// out_res    out  valid/ready    result_value, status
// cfg        in   cfg_we         cfg_wdata (notation: 0 postfix, 1 prefix)
//
// A push, an ignored operator or an operator on a short stack finishes in the execute
// state; add, subtract, multiply, a zero divisor and a power with no multiply pass finish
// as soon as see_alu starts; divide and remainder take one quotient bit per cycle in
// see_alu; power takes two multiplier passes per exponent bit.
// The stack memory has one read port, so the second operand is fetched in its own cycle.
// Reset is synchronous and clears the level, the error record and the output valid.
// A last token waits while the previous result has not been taken; no token is taken
// until the current one has finished.

module stack_expression_evaluator
  import see_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = SEE_STACK_DEPTH
)
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  see_tok_if.sink    in_tok,
  see_res_if.source  out_res,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_EXEC = 5'b00010,
    T_READ = 5'b00100,
    T_ALU  = 5'b01000,
    T_FIN  = 5'b10000
  } see_seq_state_t;

  see_seq_state_t        state_r, state_nxt;
  logic [LW-1:0]         level_r, level_nxt;
  see_status_t           err_r, err_nxt;
  logic [SEE_DATA_W-1:0] top_r, top_nxt;
  logic                  notation_r, notation_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SEE_DATA_W-1:0] out_value_r, out_value_nxt;
  see_status_t           out_status_r, out_status_nxt;

  // Token held while it is worked on.
  logic                  tok_mode_r;
  logic [SEE_DATA_W-1:0] tok_val_r;
  logic [2:0]            tok_code_r;
  logic                  tok_last_r;

  // Operand stack memory.
  logic [SEE_DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [SEE_DATA_W-1:0] rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [SEE_DATA_W-1:0] mem_wdata;
  logic                  mem_re;
  logic [LW-1:0]         level_m2;

  see_alu_req_t          alu_req;
  see_alu_rsp_t          alu_rsp;
  logic [SEE_DATA_W-1:0] alu_result;
  logic                  in_xfer;
  logic                  out_free;
  logic                  out_load;

  assign in_tok.ready = (state_r == T_IDLE);
  assign in_xfer      = in_tok.valid && in_tok.ready;
  assign out_free     = !out_valid_r || out_res.ready;
  assign level_m2     = level_r - LW'(2);

  // Operand order: prefix pops the left operand first.
  see_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .lhs    (notation_r ? top_r : rd_data_r),
    .rhs    (notation_r ? rd_data_r : top_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // Token sequencer.
  always_comb begin
    state_nxt      = state_r;
    level_nxt      = level_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    notation_nxt   = cfg_we ? cfg_wdata : notation_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_load       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = level_m2[AW-1:0];
    mem_wdata      = alu_result;
    mem_re         = 1'b0;
    alu_req        = '0;

    unique case (state_r)
      T_IDLE: begin
        if (in_xfer) begin
          state_nxt = T_EXEC;
        end
      end

      T_EXEC: begin
        state_nxt = T_FIN;
        if (!tok_mode_r) begin
          // Push, or record overflow when the stack is full.
          if (level_r < LW'(STACK_DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = level_r[AW-1:0];
            mem_wdata = tok_val_r;
            top_nxt   = tok_val_r;
            level_nxt = level_r + 1'b1;
          end else begin
            err_nxt = see_note_err(err_r, ST_OVERFLOW);
          end
        end else if (tok_code_r <= 3'(OP_REM)) begin
          if (level_r < LW'(2)) begin
            err_nxt = see_note_err(err_r, ST_UNDERFLOW);
          end else begin
            mem_re    = 1'b1;
            state_nxt = T_READ;
          end
        end
      end

      T_READ: begin
        alu_req.start = 1'b1;
        alu_req.op    = see_op_t'(tok_code_r);
        state_nxt     = T_ALU;
      end

      // The result replaces the second operand and becomes the new top.
      T_ALU: begin
        if (alu_rsp.done) begin
          mem_we    = 1'b1;
          top_nxt   = alu_result;
          level_nxt = level_r - 1'b1;
          if (alu_rsp.div0) begin
            err_nxt = see_note_err(err_r, ST_DIVZERO);
          end
          state_nxt = T_FIN;
        end
      end

      T_FIN: begin
        if (!tok_last_r) begin
          state_nxt = T_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          if (err_r != ST_OK) begin
            out_status_nxt = err_r;
          end else if (level_r == '0) begin
            out_status_nxt = ST_UNDERFLOW;
          end else if (level_r > LW'(1)) begin
            out_status_nxt = ST_LEFTOVER;
          end else begin
            out_status_nxt = ST_OK;
            out_value_nxt  = top_r;
          end
          level_nxt = '0;
          err_nxt   = ST_OK;
          state_nxt = T_IDLE;
        end
      end

      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      level_r     <= '0;
      err_r       <= ST_OK;
      notation_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      err_r       <= err_nxt;
      notation_r  <= notation_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    if (in_xfer) begin
      tok_mode_r <= in_tok.mode;
      tok_val_r  <= in_tok.operand_value;
      tok_code_r <= in_tok.operator_code;
      tok_last_r <= in_tok.last_token;
    end
  end

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= stack_mem[level_m2[AW-1:0]];
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.result_value = out_value_r;
  assign out_res.status       = out_status_r;

  // The stack level never goes beyond the stack depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  // The arithmetic unit only reports completion while the sequencer waits for it.
  a_alu_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == T_ALU))
    else $error("arithmetic completion outside wait state");

  // A recorded error holds until the expression result is loaded.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK && !out_load) |=> (err_r == $past(err_r)))
    else $error("recorded error changed within an expression");

  // Loading a result empties the stack and the error record.
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (level_r == '0 && err_r == ST_OK && out_valid_r))
    else $error("result load did not clear the expression state");

  // A result with an error status carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("error result with nonzero value");

endmodule

`default_nettype wire

// ===== hdl/see_alu.sv =====
// Iterative arithmetic unit: add, subtract, multiply, radix-2 divide and remainder,
// and square-and-multiply power on one shared 32-bit multiplier. Depends on see_pkg.
`default_nettype none

module see_alu
  import see_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire see_alu_req_t          req,
  input  wire logic [SEE_DATA_W-1:0] lhs,
  input  wire logic [SEE_DATA_W-1:0] rhs,
  output see_alu_rsp_t               rsp,
  output logic [SEE_DATA_W-1:0]      result
);

  localparam int unsigned CW = $clog2(SEE_DATA_W);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_DIV  = 5'b00010,
    A_FIX  = 5'b00100,
    A_PMUL = 5'b01000,
    A_PSQR = 5'b10000
  } see_alu_state_t;

  see_alu_state_t        state_r, state_nxt;
  logic [SEE_DATA_W-1:0] a_r, a_nxt;     // quotient / power accumulator
  logic [SEE_DATA_W-1:0] b_r, b_nxt;     // divisor magnitude / power base
  logic [SEE_DATA_W-1:0] c_r, c_nxt;     // partial remainder / exponent
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  is_rem_r, is_rem_nxt;
  logic                  negq_r, negq_nxt;
  logic                  negr_r, negr_nxt;
  logic [SEE_DATA_W-1:0] res_r, res_nxt;
  logic                  done_r, done_nxt;
  logic                  div0_r, div0_nxt;

  logic [SEE_DATA_W-1:0] mul_x, mul_y, product;
  logic [SEE_DATA_W-1:0] lhs_mag, rhs_mag;
  logic [SEE_DATA_W:0]   trial, diff;
  logic                  fits;

  // The single multiplier, shared by multiply and by both power phases.
  always_comb begin
    unique case (state_r)
      A_PMUL: begin
        mul_x = a_r;
        mul_y = b_r;
      end
      A_PSQR: begin
        mul_x = b_r;
        mul_y = b_r;
      end
      default: begin
        mul_x = lhs;
        mul_y = rhs;
      end
    endcase
  end

  assign product = mul_x * mul_y;

  // Magnitudes for division; the most negative value maps to 2^31 unsigned.
  assign lhs_mag = lhs[SEE_DATA_W-1] ? (~lhs + 1'b1) : lhs;
  assign rhs_mag = rhs[SEE_DATA_W-1] ? (~rhs + 1'b1) : rhs;

  // One restoring division step: bring down the next dividend bit and try the divisor.
  assign trial = {c_r, a_r[SEE_DATA_W-1]};
  assign diff  = trial - {1'b0, b_r};
  assign fits  = ~diff[SEE_DATA_W];

  // Sequencer of the unit.
  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    cnt_nxt    = cnt_r;
    is_rem_nxt = is_rem_r;
    negq_nxt   = negq_r;
    negr_nxt   = negr_r;
    res_nxt    = res_r;
    done_nxt   = 1'b0;
    div0_nxt   = div0_r;

    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          div0_nxt = 1'b0;
          unique case (req.op)
            OP_ADD: begin
              res_nxt  = lhs + rhs;
              done_nxt = 1'b1;
            end
            OP_SUB: begin
              res_nxt  = lhs - rhs;
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              res_nxt  = product;
              done_nxt = 1'b1;
            end
            OP_DIV, OP_REM: begin
              if (rhs == '0) begin
                res_nxt  = '0;
                div0_nxt = 1'b1;
                done_nxt = 1'b1;
              end else begin
                a_nxt      = lhs_mag;
                b_nxt      = rhs_mag;
                c_nxt      = '0;
                cnt_nxt    = '0;
                is_rem_nxt = (req.op == OP_REM);
                negq_nxt   = lhs[SEE_DATA_W-1] ^ rhs[SEE_DATA_W-1];
                negr_nxt   = lhs[SEE_DATA_W-1];
                state_nxt  = A_DIV;
              end
            end
            OP_POW: begin
              if (rhs[SEE_DATA_W-1]) begin
                // Negative exponent truncates to zero except for unit bases.
                done_nxt = 1'b1;
                if (lhs == SEE_DATA_W'(1)) begin
                  res_nxt = SEE_DATA_W'(1);
                end else if (lhs == '1) begin
                  res_nxt = rhs[0] ? '1 : SEE_DATA_W'(1);
                end else begin
                  res_nxt  = '0;
                  div0_nxt = (lhs == '0);
                end
              end else if (rhs == '0) begin
                res_nxt  = SEE_DATA_W'(1);
                done_nxt = 1'b1;
              end else begin
                a_nxt     = SEE_DATA_W'(1);
                b_nxt     = lhs;
                c_nxt     = rhs;
                state_nxt = A_PMUL;
              end
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end

      A_DIV: begin
        a_nxt   = {a_r[SEE_DATA_W-2:0], fits};
        c_nxt   = fits ? diff[SEE_DATA_W-1:0] : trial[SEE_DATA_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(SEE_DATA_W - 1)) begin
          state_nxt = A_FIX;
        end
      end

      // Apply the signs: quotient toward zero, remainder takes the dividend's sign.
      A_FIX: begin
        if (is_rem_r) begin
          res_nxt = negr_r ? (~c_r + 1'b1) : c_r;
        end else begin
          res_nxt = negq_r ? (~a_r + 1'b1) : a_r;
        end
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end

      // Fold the base into the accumulator when the exponent bit is set.
      A_PMUL: begin
        if (c_r[0]) begin
          a_nxt = product;
        end
        state_nxt = A_PSQR;
      end

      // Square the base and move to the next exponent bit.
      A_PSQR: begin
        b_nxt = product;
        c_nxt = c_r >> 1;
        if ((c_r >> 1) == '0) begin
          res_nxt   = a_r;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end else begin
          state_nxt = A_PMUL;
        end
      end

      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    cnt_r    <= cnt_nxt;
    is_rem_r <= is_rem_nxt;
    negq_r   <= negq_nxt;
    negr_r   <= negr_nxt;
    res_r    <= res_nxt;
    div0_r   <= div0_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.div0 = div0_r;
  assign result   = res_r;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the stack expression evaluator: directed token table, then random expressions.
// Every result is checked against a token-by-token predictor of the operand stack.
// Depends on see_pkg, the see_tok_if and see_res_if channels and the evaluator RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import see_pkg::*;

  localparam int unsigned DEPTH          = SEE_STACK_DEPTH;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 100;
  localparam int          PHASE_TOKENS   = 200;
  localparam int          PHASE_COUNT    = 5;

  // Token kinds and the two operator codes that the block ignores.
  localparam bit         MODE_PUSH   = 1'b0;
  localparam bit         MODE_APPLY  = 1'b1;
  localparam logic [2:0] CODE_SPARE_A = 3'd6;
  localparam logic [2:0] CODE_SPARE_B = 3'd7;

  typedef struct packed {
    bit [31:0]   value;
    see_status_t status;
  } answer_t;

  typedef struct packed {
    bit          mode;
    bit [31:0]   value;
    bit [2:0]    code;
    bit          last;
    bit          pinned;
    bit [31:0]   want_value;
    see_status_t want_status;
  } script_row_t;

  // Opening table, postfix notation. Pinned rows carry their expected answer.
  localparam script_row_t OPENING_ROWS [0:28] = '{
    // Operator on an empty stack ends the expression.
    '{MODE_APPLY, 32'h0, OP_ADD, 1'b1, 1'b1, 32'h0, ST_UNDERFLOW},
    // Largest value plus one wraps to the most negative value.
    '{MODE_PUSH, 32'h7FFF_FFFF, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'h0000_0001, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_APPLY, 32'h0, OP_ADD, 1'b1, 1'b1, 32'h8000_0000, ST_OK},
    // Most negative value divided by minus one.
    '{MODE_PUSH, 32'h8000_0000, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'hFFFF_FFFF, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_APPLY, 32'h0, OP_DIV, 1'b1, 1'b1, 32'h8000_0000, ST_OK},
    // And its remainder.
    '{MODE_PUSH, 32'h8000_0000, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'hFFFF_FFFF, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_APPLY, 32'h0, OP_REM, 1'b1, 1'b1, 32'h0, ST_OK},
    // Remainder by zero.
    '{MODE_PUSH, 32'h0000_0005, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'h0000_0000, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_APPLY, 32'h0, OP_REM, 1'b1, 1'b1, 32'h0, ST_DIVZERO},
    // An underflow stays recorded over a later divide by zero.
    '{MODE_APPLY, 32'h0, OP_SUB, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'h0000_0001, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'h0000_0000, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_APPLY, 32'h0, OP_DIV, 1'b1, 1'b1, 32'h0, ST_UNDERFLOW},
    // Zero raised to a negative exponent.
    '{MODE_PUSH, 32'h0000_0000, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'hFFFF_FFFF, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_APPLY, 32'h0, OP_POW, 1'b1, 1'b1, 32'h0, ST_DIVZERO},
    // A longer expression with an ignored operator in the middle.
    '{MODE_PUSH, 32'hFFFF_FFFD, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'h0000_0003, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_APPLY, 32'h0, OP_POW, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_APPLY, 32'h0, CODE_SPARE_B, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'h0000_0007, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_APPLY, 32'h0, OP_MUL, 1'b1, 1'b0, 32'h0, ST_OK},
    // Ignored operator as the last token of an empty expression.
    '{MODE_APPLY, 32'h0, CODE_SPARE_A, 1'b1, 1'b1, 32'h0, ST_UNDERFLOW},
    // Two values left over.
    '{MODE_PUSH, 32'h0000_0001, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{MODE_PUSH, 32'h0000_0002, OP_ADD, 1'b1, 1'b1, 32'h0, ST_LEFTOVER}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  see_tok_if in_tok ();
  see_res_if out_res ();

  stack_expression_evaluator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tok    (in_tok),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: a shadow of the operand stack and the notation register.
  bit [31:0]   shadow_stack [DEPTH];
  int unsigned shadow_level;
  see_status_t shadow_fault;
  bit          shadow_notation;

  answer_t answers_due [$];
  bit      pin_on;
  answer_t pin_answer;
  bit      calm_run;
  int      faults;
  int      tokens_taken;
  int      tokens_counted;
  int      answers_checked;
  int      status_tally [5];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void record_fault(see_status_t code);
    if (shadow_fault == ST_OK) shadow_fault = code;
  endfunction

  // Integer power by square and multiply; negative exponents truncate toward zero.
  function automatic bit [31:0] power_wrap(bit [31:0] base, bit [31:0] ex, output bit dz);
    bit [31:0] acc;
    bit [31:0] sq;
    bit [31:0] e;
    dz = 1'b0;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
      if (base == 32'd0) dz = 1'b1;
      return 32'd0;
    end
    acc = 32'd1;
    sq = base;
    e = ex;
    while (e != 0) begin
      if (e[0]) acc = acc * sq;
      sq = sq * sq;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit [31:0] apply_operator(bit [31:0] lhs, bit [31:0] rhs, see_op_t op,
                                               output bit dz);
    longint a;
    longint b;
    dz = 1'b0;
    a = $signed(lhs);
    b = $signed(rhs);
    case (op)
      OP_ADD: return lhs + rhs;
      OP_SUB: return lhs - rhs;
      OP_MUL: return lhs * rhs;
      OP_POW: return power_wrap(lhs, rhs, dz);
      OP_DIV: begin
        if (b == 0) begin
          dz = 1'b1;
          return 32'd0;
        end
        return 32'(a / b);
      end
      default: begin
        if (b == 0) begin
          dz = 1'b1;
          return 32'd0;
        end
        return 32'(a % b);
      end
    endcase
  endfunction

  // Advance the shadow stack by one accepted token and queue the answer it closes.
  task automatic evaluate_token(bit mode, bit [31:0] value, bit [2:0] code, bit last);
    bit [31:0] top;
    bit [31:0] under;
    bit [31:0] outcome;
    bit        dz;
    answer_t   ans;
    if (mode == MODE_PUSH) begin
      if (shadow_level < DEPTH) begin
        shadow_stack[shadow_level] = value;
        shadow_level++;
      end else begin
        record_fault(ST_OVERFLOW);
      end
    end else if (code != CODE_SPARE_A && code != CODE_SPARE_B) begin
      if (shadow_level < 2) begin
        record_fault(ST_UNDERFLOW);
      end else begin
        top = shadow_stack[shadow_level - 1];
        under = shadow_stack[shadow_level - 2];
        // In prefix the value popped first is the left operand.
        if (shadow_notation) outcome = apply_operator(top, under, see_op_t'(code), dz);
        else outcome = apply_operator(under, top, see_op_t'(code), dz);
        if (dz) record_fault(ST_DIVZERO);
        shadow_level--;
        shadow_stack[shadow_level - 1] = outcome;
      end
    end
    if (last) begin
      ans.value = 32'd0;
      if (shadow_fault != ST_OK) ans.status = shadow_fault;
      else if (shadow_level == 0) ans.status = ST_UNDERFLOW;
      else if (shadow_level > 1) ans.status = ST_LEFTOVER;
      else begin
        ans.status = ST_OK;
        ans.value = shadow_stack[0];
      end
      if (pin_on) ans = pin_answer;
      answers_due.push_back(ans);
      shadow_level = 0;
      shadow_fault = ST_OK;
    end
  endtask

  task automatic check_answer(logic [31:0] value, logic [2:0] status);
    answer_t due;
    if (answers_due.size() == 0) begin
      faults++;
      $display("%0t: result with none expected, actual value %h status %0d",
               $time, value, status);
    end else begin
      due = answers_due.pop_front();
      answers_checked++;
      status_tally[int'(due.status)]++;
      if (value !== due.value) begin
        faults++;
        $display("%0t: result_value mismatch, expected %h, actual %h", $time, due.value, value);
      end
      if (status !== due.status) begin
        faults++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, due.status, status);
      end
    end
  endtask

  // Monitor: predicts on every token transfer and checks every result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) shadow_notation = cfg_wdata;
      if (in_tok.valid && in_tok.ready) begin
        tokens_taken++;
        evaluate_token(in_tok.mode, in_tok.operand_value, in_tok.operator_code,
                       in_tok.last_token);
      end
      if (out_res.valid && out_res.ready) check_answer(out_res.result_value, out_res.status);
    end
  end

  // Result side: ready drops in random bursts, never during the calm phase.
  initial begin : result_sink
    int stall;
    stall = 0;
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_run) stall = 0;
      else if (stall == 0 && $urandom_range(0, 11) == 0) stall = $urandom_range(1, 18);
      if (stall > 0) begin
        out_res.ready <= 1'b0;
        stall--;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tok.valid && in_tok.ready) || (out_res.valid && out_res.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit [31:0] pick_value();
    bit [31:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        v = $urandom_range(0, 12);
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Present one token and hold it until its transfer, with an optional gap before it.
  task automatic send_token(bit mode, bit [31:0] value, bit [2:0] code, bit last,
                            bit pinned = 1'b0, answer_t pinned_answer = '0);
    int gap;
    if (!calm_run && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_tok.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tok.valid <= 1'b1;
    in_tok.mode <= mode;
    in_tok.operand_value <= (mode == MODE_PUSH) ? value : $urandom();
    in_tok.operator_code <= (mode == MODE_APPLY) ? code : 3'($urandom_range(0, 7));
    in_tok.last_token <= last;
    pin_on = pinned;
    pin_answer = pinned_answer;
    if (!(mode == MODE_APPLY && !last && (code == CODE_SPARE_A || code == CODE_SPARE_B)))
      tokens_counted++;
    do @(posedge clk); while (in_tok.ready !== 1'b1);
  endtask

  task automatic drain_answers();
    @(negedge clk);
    in_tok.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // Idle point: all answers in, plus time for a token that closes no expression.
  task automatic settle();
    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_notation(bit prefix);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= prefix;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Well-formed expression: the stack never runs short and ends with one value.
  task automatic send_expression();
    int unsigned operands;
    int unsigned level;
    operands = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 15) : $urandom_range(1, 5);
    level = 0;
    while (operands > 0 || level > 1) begin
      if ($urandom_range(0, 24) == 0)
        send_token(MODE_APPLY, 32'd0, $urandom_range(0, 1) ? CODE_SPARE_A : CODE_SPARE_B, 1'b0);
      if (level >= 2 && (operands == 0 || $urandom_range(0, 2) == 0)) begin
        level--;
        send_token(MODE_APPLY, 32'd0, 3'($urandom_range(0, 5)), operands == 0 && level == 1);
      end else begin
        operands--;
        level++;
        send_token(MODE_PUSH, pick_value(), 3'd0, operands == 0 && level == 1);
      end
    end
  endtask

  // Pushes past the top of the stack, then a few operators.
  task automatic send_fill();
    int pushes;
    int ops;
    pushes = DEPTH + $urandom_range(1, 3);
    ops = $urandom_range(1, 3);
    repeat (pushes) send_token(MODE_PUSH, pick_value(), 3'd0, 1'b0);
    for (int i = 1; i <= ops; i++)
      send_token(MODE_APPLY, 32'd0, 3'($urandom_range(0, 5)), i == ops);
  endtask

  // Short runs of unconstrained tokens: broken expressions and stray operators.
  task automatic send_noise();
    int count;
    count = $urandom_range(1, 6);
    repeat (count)
      send_token(1'($urandom_range(0, 1)), pick_value(), 3'($urandom_range(0, 7)),
                 $urandom_range(0, 3) == 0);
  endtask

  initial begin : stimulus
    int      sent_goal;
    answer_t pinned;
    in_tok.valid = 1'b0;
    in_tok.mode = MODE_PUSH;
    in_tok.operand_value = '0;
    in_tok.operator_code = OP_ADD;
    in_tok.last_token = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    rst_n = 1'b0;
    calm_run = 1'b0;
    pin_on = 1'b0;
    pin_answer = '0;
    shadow_level = 0;
    shadow_fault = ST_OK;
    shadow_notation = 1'b0;
    faults = 0;
    tokens_taken = 0;
    tokens_counted = 0;
    answers_checked = 0;
    foreach (status_tally[i]) status_tally[i] = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table in postfix notation.
    write_notation(1'b0);
    for (int i = 0; i < $size(OPENING_ROWS); i++) begin
      pinned.value = OPENING_ROWS[i].want_value;
      pinned.status = OPENING_ROWS[i].want_status;
      send_token(OPENING_ROWS[i].mode, OPENING_ROWS[i].value, OPENING_ROWS[i].code,
                 OPENING_ROWS[i].last, OPENING_ROWS[i].pinned, pinned);
    end

    // Random phases, each under its own notation; the last one runs without idling.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      write_notation(phase < 3 ? (phase % 2 == 0) : bit'($urandom_range(0, 1)));
      calm_run = (phase == PHASE_COUNT - 1);
      sent_goal = tokens_counted + PHASE_TOKENS;
      while (tokens_counted < sent_goal) begin
        case ($urandom_range(0, 39))
          0: send_fill();
          1, 2, 3, 4, 5, 6, 7, 8: send_noise();
          default: send_expression();
        endcase
        if (!calm_run && $urandom_range(0, 29) == 0) drain_answers();
      end
    end
    settle();

    $display("Covered %0d tokens and %0d checked results over postfix and prefix phases.",
             tokens_taken, answers_checked);
    $display("Statuses seen: ok %0d, underflow %0d, overflow %0d, divide by zero %0d, leftover %0d",
             status_tally[ST_OK], status_tally[ST_UNDERFLOW], status_tally[ST_OVERFLOW],
             status_tally[ST_DIVZERO], status_tally[ST_LEFTOVER]);
    if (faults == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
